@@ rtl/core/mtcg_pkg.sv @@
package mtcg_pkg;

    // Default sizes of the count store and the data path
    localparam int GRID_ROWS_MAX_DEF = 256;
    localparam int GRID_COLS_MAX_DEF = 256;
    localparam int COUNT_BITS_DEF    = 15;
    localparam int COORD_BITS_DEF    = 48;

    // Fixed field widths
    localparam int CFG_IDX_W  = 3;
    localparam int GRID_CFG_W = 9;
    localparam int INV_W      = 32;
    localparam int MASK_W     = 8;
    localparam int CELL_W     = 8;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_NORTHING = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_EASTING  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_STEP_NORTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_STEP_EAST   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS       = 3'd5;

    // Register reset values
    localparam logic [INV_W-1:0]      INV_STEP_RST  = 32'd65536;
    localparam logic [GRID_CFG_W-1:0] GRID_SIZE_RST = 9'd256;

    // Request kinds
    localparam logic REQ_ACCUM = 1'b0;
    localparam logic REQ_READ  = 1'b1;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIFF,
        ST_MUL,
        ST_IDX,
        ST_RD
    } state_t;

endpackage

@@ rtl/core/mask_to_coarse_grid_binning_top.sv @@
// Channel   Direction  Handshake                     Contents
// s_axis    in         s_axis_tvalid/s_axis_tready   pixel or read request word
// m_axis    out        m_axis_tvalid/m_axis_tready   one result word per request
// cfg       in         cfg_valid/cfg_ready           register index and write data
//
// An accumulate request steps through difference, multiply, index and bounds with
// store read, then write-back and result load; a read request skips difference and
// multiply. One request is in work at a time: no new word is taken until the result
// load, and the next word can be taken in the cycle after it.
// After reset the count store is cleared one entry a cycle, all
// 2^(clog2(GRID_ROWS_MAX)+clog2(GRID_COLS_MAX)) entries (65536 by default);
// s_axis_tready stays low meanwhile, configuration writes are taken.
// The result register frees the request side: a new word is accepted while
// a result still waits; the write-back holds only while that register is full.

module mask_to_coarse_grid_binning_top #(
    parameter int GRID_ROWS_MAX = mtcg_pkg::GRID_ROWS_MAX_DEF,
    parameter int GRID_COLS_MAX = mtcg_pkg::GRID_COLS_MAX_DEF,
    parameter int COUNT_BITS    = mtcg_pkg::COUNT_BITS_DEF,
    parameter int COORD_BITS    = mtcg_pkg::COORD_BITS_DEF,
    localparam int IN_W  = ((2 * COORD_BITS + mtcg_pkg::MASK_W + 2 * mtcg_pkg::CELL_W + 7) / 8)
                           * 8,
    localparam int OUT_W = ((1 + 2 * mtcg_pkg::CELL_W + COUNT_BITS + 7) / 8) * 8,
    localparam int CFG_W = (COORD_BITS > mtcg_pkg::INV_W) ? COORD_BITS : mtcg_pkg::INV_W
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // request side
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // pixel_northing, pixel_easting, mask_value, read_row, read_col, zero fill
    input  logic [IN_W-1:0]                s_axis_tdata,
    // req_type
    input  logic [0:0]                     s_axis_tuser,
    // result side
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // counted, cell_row, cell_col, cell_count, zero fill
    output logic [OUT_W-1:0]               m_axis_tdata,
    // configuration writes
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [mtcg_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]               cfg_data
);

    localparam int RB      = (GRID_ROWS_MAX > 1) ? $clog2(GRID_ROWS_MAX) : 1;
    localparam int CB      = (GRID_COLS_MAX > 1) ? $clog2(GRID_COLS_MAX) : 1;
    localparam int ADDR_W  = RB + CB;
    localparam int DEPTH   = 1 << ADDR_W;
    localparam int RLW_MIN = $clog2(GRID_ROWS_MAX + 1);
    localparam int CLW_MIN = $clog2(GRID_COLS_MAX + 1);
    localparam int RLW     = (RLW_MIN > mtcg_pkg::GRID_CFG_W) ? RLW_MIN : mtcg_pkg::GRID_CFG_W;
    localparam int CLW     = (CLW_MIN > mtcg_pkg::GRID_CFG_W) ? CLW_MIN : mtcg_pkg::GRID_CFG_W;
    localparam int DW      = COORD_BITS + 1;
    localparam int MAG_W   = (DW > 33) ? DW : 33;
    localparam int HI_W    = MAG_W - 32;
    localparam int HP_W    = HI_W + mtcg_pkg::INV_W;
    localparam int QW      = ((HP_W > 41) ? HP_W : 41) + 1;
    localparam int C2      = 2 * COORD_BITS;
    localparam int MW      = mtcg_pkg::MASK_W;
    localparam int EW      = mtcg_pkg::CELL_W;
    localparam int PAY_W   = 1 + 2 * EW + COUNT_BITS;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    // configuration registers
    logic signed [COORD_BITS-1:0]         org_n_reg;
    logic signed [COORD_BITS-1:0]         org_e_reg;
    logic [mtcg_pkg::INV_W-1:0]           inv_n_reg;
    logic [mtcg_pkg::INV_W-1:0]           inv_e_reg;
    logic [mtcg_pkg::GRID_CFG_W-1:0]      rows_reg;
    logic [mtcg_pkg::GRID_CFG_W-1:0]      cols_reg;

    // sequencer
    mtcg_pkg::state_t state_reg, state_next;
    logic [ADDR_W-1:0] clr_addr_reg;
    logic              in_take;
    logic              mem_re;
    logic              out_load;

    // request word
    logic                         req_read_reg;
    logic signed [COORD_BITS-1:0] pn_reg;
    logic signed [COORD_BITS-1:0] pe_reg;
    logic [MW-1:0]                mask_reg;
    logic [EW-1:0]                rrow_reg;
    logic [EW-1:0]                rcol_reg;

    // arithmetic stages
    logic              neg_n_reg, neg_e_reg;
    logic [MAG_W-1:0]  mag_n_reg, mag_e_reg;
    logic [HP_W-1:0]   hp_n_reg, hp_e_reg;
    logic [63:0]       lp_n_reg, lp_e_reg;
    logic              hit_reg;
    logic [EW-1:0]     row8_reg, col8_reg;

    // count store
    logic [COUNT_BITS-1:0] count_mem [DEPTH];
    logic [COUNT_BITS-1:0] mem_rd_reg;
    logic [ADDR_W-1:0]     mem_raddr;
    logic [ADDR_W-1:0]     mem_raddr_reg;
    logic                  mem_we;
    logic [ADDR_W-1:0]     mem_waddr;
    logic [COUNT_BITS-1:0] mem_wdata;

    // result register
    logic             out_valid_reg, out_valid_next;
    logic [OUT_W-1:0] out_data_reg;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == mtcg_pkg::ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // configuration write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            org_n_reg <= '0;
            org_e_reg <= '0;
            inv_n_reg <= mtcg_pkg::INV_STEP_RST;
            inv_e_reg <= mtcg_pkg::INV_STEP_RST;
            rows_reg  <= mtcg_pkg::GRID_SIZE_RST;
            cols_reg  <= mtcg_pkg::GRID_SIZE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                mtcg_pkg::CFG_ORIGIN_NORTHING: org_n_reg <= cfg_data[COORD_BITS-1:0];
                mtcg_pkg::CFG_ORIGIN_EASTING:  org_e_reg <= cfg_data[COORD_BITS-1:0];
                mtcg_pkg::CFG_INV_STEP_NORTH:  inv_n_reg <= cfg_data[mtcg_pkg::INV_W-1:0];
                mtcg_pkg::CFG_INV_STEP_EAST:   inv_e_reg <= cfg_data[mtcg_pkg::INV_W-1:0];
                mtcg_pkg::CFG_GRID_ROWS:       rows_reg  <= cfg_data[mtcg_pkg::GRID_CFG_W-1:0];
                mtcg_pkg::CFG_GRID_COLS:       cols_reg  <= cfg_data[mtcg_pkg::GRID_CFG_W-1:0];
                default: ;
            endcase
        end
    end

    // state register and clear counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mtcg_pkg::ST_CLEAR;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (state_reg == mtcg_pkg::ST_CLEAR)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
        end
    end

    // next state and step controls
    always_comb
    begin
        state_next = state_reg;
        in_take    = 1'b0;
        mem_re     = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            mtcg_pkg::ST_CLEAR:
            begin
                if (&clr_addr_reg)
                begin
                    state_next = mtcg_pkg::ST_IDLE;
                end
            end
            mtcg_pkg::ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    in_take    = 1'b1;
                    state_next = (s_axis_tuser[0] == mtcg_pkg::REQ_READ) ?
                                 mtcg_pkg::ST_IDX : mtcg_pkg::ST_DIFF;
                end
            end
            mtcg_pkg::ST_DIFF: state_next = mtcg_pkg::ST_MUL;
            mtcg_pkg::ST_MUL:  state_next = mtcg_pkg::ST_IDX;
            mtcg_pkg::ST_IDX:
            begin
                mem_re     = 1'b1;
                state_next = mtcg_pkg::ST_RD;
            end
            mtcg_pkg::ST_RD:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_load   = 1'b1;
                    state_next = mtcg_pkg::ST_IDLE;
                end
            end
            default: state_next = mtcg_pkg::ST_IDLE;
        endcase
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // request capture
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            req_read_reg <= s_axis_tuser[0];
            pn_reg       <= s_axis_tdata[COORD_BITS-1:0];
            pe_reg       <= s_axis_tdata[C2-1:COORD_BITS];
            mask_reg     <= s_axis_tdata[C2+MW-1:C2];
            rrow_reg     <= s_axis_tdata[C2+MW+EW-1:C2+MW];
            rcol_reg     <= s_axis_tdata[C2+MW+2*EW-1:C2+MW+EW];
        end
    end

    // signed differences and their magnitudes
    logic signed [DW-1:0] dn, de;
    logic [DW-1:0]        an, ae;

    always_comb
    begin
        dn = {org_n_reg[COORD_BITS-1], org_n_reg} - {pn_reg[COORD_BITS-1], pn_reg};
        de = {pe_reg[COORD_BITS-1], pe_reg} - {org_e_reg[COORD_BITS-1], org_e_reg};
        an = dn[DW-1] ? DW'(-dn) : DW'(dn);
        ae = de[DW-1] ? DW'(-de) : DW'(de);
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == mtcg_pkg::ST_DIFF)
        begin
            neg_n_reg <= dn[DW-1];
            neg_e_reg <= de[DW-1];
            mag_n_reg <= MAG_W'(an);
            mag_e_reg <= MAG_W'(ae);
        end
    end

    // partial products of magnitude and reciprocal
    always_ff @(posedge clk)
    begin
        if (state_reg == mtcg_pkg::ST_MUL)
        begin
            hp_n_reg <= HP_W'(mag_n_reg[MAG_W-1:32]) * HP_W'(inv_n_reg);
            hp_e_reg <= HP_W'(mag_e_reg[MAG_W-1:32]) * HP_W'(inv_e_reg);
            lp_n_reg <= 64'(mag_n_reg[31:0]) * 64'(inv_n_reg);
            lp_e_reg <= 64'(mag_e_reg[31:0]) * 64'(inv_e_reg);
        end
    end

    // rounding, bounds test and store address
    logic [RLW-1:0] lim_r;
    logic [CLW-1:0] lim_c;
    logic [QW-1:0]  hpx_n, hpx_e, q_n, q_e;
    logic           ok_n, ok_e;
    logic [RLW-1:0] rrow_x;
    logic [CLW-1:0] rcol_x;
    logic           hit_acc, hit_rd, hit;

    always_comb
    begin
        lim_r  = (RLW'(rows_reg) > RLW'(GRID_ROWS_MAX)) ? RLW'(GRID_ROWS_MAX) : RLW'(rows_reg);
        lim_c  = (CLW'(cols_reg) > CLW'(GRID_COLS_MAX)) ? CLW'(GRID_COLS_MAX) : CLW'(cols_reg);
        hpx_n  = QW'(hp_n_reg);
        hpx_e  = QW'(hp_e_reg);
        q_n    = hpx_n + QW'(lp_n_reg[63:32]) + QW'(lp_n_reg[31]);
        q_e    = hpx_e + QW'(lp_e_reg[63:32]) + QW'(lp_e_reg[31]);
        ok_n   = (hpx_n < (QW'(1) << 40)) && !(neg_n_reg && (q_n != '0)) &&
                 (q_n < QW'(lim_r));
        ok_e   = (hpx_e < (QW'(1) << 40)) && !(neg_e_reg && (q_e != '0)) &&
                 (q_e < QW'(lim_c));
        hit_acc = ok_n && ok_e;
        rrow_x = RLW'(rrow_reg);
        rcol_x = CLW'(rcol_reg);
        hit_rd = (rrow_x < RLW'(GRID_ROWS_MAX)) && (rcol_x < CLW'(GRID_COLS_MAX));
        if (req_read_reg == mtcg_pkg::REQ_READ)
        begin
            hit       = hit_rd;
            mem_raddr = {rrow_x[RB-1:0], rcol_x[CB-1:0]};
        end
        else
        begin
            hit       = hit_acc;
            mem_raddr = {q_n[RB-1:0], q_e[CB-1:0]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == mtcg_pkg::ST_IDX)
        begin
            hit_reg       <= hit;
            row8_reg      <= q_n[EW-1:0];
            col8_reg      <= q_e[EW-1:0];
            mem_raddr_reg <= mem_raddr;
        end
    end

    // update of the cell and the result word
    logic                  mask_pos;
    logic [COUNT_BITS-1:0] cnt_inc;
    logic                  r_counted;
    logic [EW-1:0]         r_row, r_col;
    logic [COUNT_BITS-1:0] r_cnt;

    always_comb
    begin
        mask_pos  = !mask_reg[MW-1] && (mask_reg != '0);
        cnt_inc   = (mem_rd_reg < COUNT_MAX) ? mem_rd_reg + 1'b1 : mem_rd_reg;
        r_counted = 1'b0;
        r_row     = '0;
        r_col     = '0;
        r_cnt     = '0;
        if (req_read_reg == mtcg_pkg::REQ_READ)
        begin
            r_row = rrow_reg;
            r_col = rcol_reg;
            r_cnt = hit_reg ? mem_rd_reg : '0;
        end
        else if (hit_reg)
        begin
            r_counted = mask_pos;
            r_row     = row8_reg;
            r_col     = col8_reg;
            r_cnt     = mask_pos ? cnt_inc : mem_rd_reg;
        end
        // store write port: clearing pass or write-back
        if (state_reg == mtcg_pkg::ST_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_reg;
            mem_wdata = '0;
        end
        else
        begin
            mem_we    = out_load && (req_read_reg == mtcg_pkg::REQ_ACCUM) && hit_reg &&
                        mask_pos;
            mem_waddr = mem_raddr_reg;
            mem_wdata = cnt_inc;
        end
    end

    // count store, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            count_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_rd_reg <= count_mem[mem_raddr];
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= OUT_W'(PAY_W'({r_cnt, r_col, r_row, r_counted}));
        end
    end

endmodule

@@ rtl/core/mtcg_checker.sv @@
module mtcg_checker #(
    parameter int COUNT_BITS = mtcg_pkg::COUNT_BITS_DEF,
    localparam int OUT_W = ((1 + 2 * mtcg_pkg::CELL_W + COUNT_BITS + 7) / 8) * 8,
    localparam int CNT_LO = 1 + 2 * mtcg_pkg::CELL_W
) (
    input logic             clk,
    input logic             rst_n,
    input logic             s_axis_tvalid,
    input logic             s_axis_tready,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [OUT_W-1:0] m_axis_tdata
);

    // a stalled result word stays in place
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    // a counted pixel always leaves a nonzero count
    a_counted_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[CNT_LO+COUNT_BITS-1:CNT_LO] != '0)
        else $error("counted result with zero count");

    // one request in work: no accept in the cycle after an accept
    a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request accepted back to back");

    // no result appears the cycle right after an accept
    a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
        else $error("result appeared too early");

endmodule

bind mask_to_coarse_grid_binning_top mtcg_checker #(
    .COUNT_BITS (COUNT_BITS)
) u_mtcg_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

    localparam int COORD_W  = mtcg_pkg::COORD_BITS_DEF;
    localparam int CNT_W    = mtcg_pkg::COUNT_BITS_DEF;
    localparam int MASK_W   = mtcg_pkg::MASK_W;
    localparam int CELL_W   = mtcg_pkg::CELL_W;
    localparam int INV_W    = mtcg_pkg::INV_W;
    localparam int GRID_W   = mtcg_pkg::GRID_CFG_W;
    localparam int IDX_W    = mtcg_pkg::CFG_IDX_W;
    localparam int ROWS_MAX = mtcg_pkg::GRID_ROWS_MAX_DEF;
    localparam int COLS_MAX = mtcg_pkg::GRID_COLS_MAX_DEF;
    localparam int IN_W     = ((2 * COORD_W + MASK_W + 2 * CELL_W + 7) / 8) * 8;
    localparam int OUT_W    = ((1 + 2 * CELL_W + CNT_W + 7) / 8) * 8;
    localparam int CFG_W    = (COORD_W > INV_W) ? COORD_W : INV_W;
    localparam int CELLS    = ROWS_MAX * COLS_MAX;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // watchdog limit on quiet cycles, well above the store clear after reset
    localparam int WATCHDOG_LIMIT = 300000;
    localparam int DRAIN_CYCLES   = 20;
    localparam int PHASE_WORDS    = 130;
    localparam int HIT_WORDS      = 90;

    typedef struct {
        logic                      kind;
        logic signed [COORD_W-1:0] north;
        logic signed [COORD_W-1:0] east;
        logic signed [MASK_W-1:0]  mask;
        logic [CELL_W-1:0]         rd_row;
        logic [CELL_W-1:0]         rd_col;
    } bin_req_t;

    typedef struct {
        logic              counted;
        logic [CELL_W-1:0] row;
        logic [CELL_W-1:0] col;
        logic [CNT_W-1:0]  count;
    } cell_res_t;

    typedef struct {
        bin_req_t  w;
        bit        typed;
        cell_res_t want;
    } probe_t;

    logic                 clk;
    logic                 rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [IN_W-1:0]      s_axis_tdata;   // north, east, mask, read row, read col
    logic [0:0]           s_axis_tuser;   // req_type
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [OUT_W-1:0]     m_axis_tdata;   // counted, row, col, count
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [IDX_W-1:0]     cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    // shadow of the register file and the count store
    logic signed [COORD_W-1:0] cfg_on;
    logic signed [COORD_W-1:0] cfg_oe;
    logic [INV_W-1:0]          cfg_inv_n;
    logic [INV_W-1:0]          cfg_inv_e;
    logic [GRID_W-1:0]         cfg_rows;
    logic [GRID_W-1:0]         cfg_cols;
    logic [CNT_W-1:0]          cell_cnt [CELLS];

    cell_res_t pending_results [$];
    bit        idle_en;
    int        err_cnt;
    int        n_words;
    int        n_checked;
    int        n_hits;
    int        n_sat;
    int        n_configs;
    int        quiet;

    mask_to_coarse_grid_binning_top u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // round((a - b) * inv / 2^32) half away from zero; 1 when in [0, lim)
    function automatic bit grid_index(input logic signed [COORD_W-1:0] a,
                                      input logic signed [COORD_W-1:0] b,
                                      input logic [INV_W-1:0] inv,
                                      input int unsigned lim,
                                      output int unsigned idx);
        logic signed [COORD_W:0] diff;
        logic [COORD_W:0]        mag;
        logic [COORD_W+33:0]     prod;
        logic [COORD_W+1:0]      q;
        diff = (COORD_W+1)'(a) - (COORD_W+1)'(b);
        mag  = diff[COORD_W] ? -diff : diff;
        prod = (COORD_W+34)'(mag) * (COORD_W+34)'(inv);
        prod = prod + (COORD_W+34)'(32'h8000_0000);
        q    = prod[COORD_W+33:32];
        idx  = 0;
        if (diff < 0 && q != 0)
            return 1'b0;
        if (q >= lim)
            return 1'b0;
        idx = q[31:0];
        return 1'b1;
    endfunction

    // expected result of one request; updates the shadow store
    function automatic cell_res_t bin_request(input bin_req_t w);
        cell_res_t   res;
        int unsigned rlim;
        int unsigned clim;
        int unsigned r;
        int unsigned c;
        int unsigned k;
        logic [CNT_W-1:0] v;
        res = '{1'b0, '0, '0, '0};
        rlim = (cfg_rows > ROWS_MAX) ? ROWS_MAX : cfg_rows;
        clim = (cfg_cols > COLS_MAX) ? COLS_MAX : cfg_cols;
        if (w.kind == mtcg_pkg::REQ_READ)
        begin
            res.row   = w.rd_row;
            res.col   = w.rd_col;
            res.count = cell_cnt[w.rd_row * COLS_MAX + w.rd_col];
        end
        else if (grid_index(cfg_on, w.north, cfg_inv_n, rlim, r) &&
                 grid_index(w.east, cfg_oe, cfg_inv_e, clim, c))
        begin
            k = r * COLS_MAX + c;
            v = cell_cnt[k];
            if (w.mask > 0)
            begin
                res.counted = 1'b1;
                if (v != CNT_MAX)
                    v = v + 1'b1;
                cell_cnt[k] = v;
            end
            res.row   = CELL_W'(r);
            res.col   = CELL_W'(c);
            res.count = v;
        end
        return res;
    endfunction

    // coordinate near cell index k of the current grid, k in [-1, lim]
    function automatic logic signed [COORD_W-1:0] aim(input logic signed [COORD_W-1:0] org,
                                                      input logic [INV_W-1:0] inv,
                                                      input int lim,
                                                      input bit down);
        logic [63:0]               step;
        logic signed [COORD_W-1:0] off;
        logic signed [COORD_W-1:0] jit;
        int                        k;
        if (inv == 0)
            return COORD_W'({$urandom, $urandom});
        step = 64'h1_0000_0000 / inv;
        k    = int'($urandom_range(0, lim + 1)) - 1;
        off  = $signed(step[COORD_W-1:0]) * k;
        jit  = COORD_W'($urandom_range(0, 32'(step >> 1))) - COORD_W'(step >> 2);
        return down ? org - off + jit : org + off + jit;
    endfunction

    // mostly aimed pixels, some reads, some pure noise
    function automatic bin_req_t random_word();
        bin_req_t    w;
        int unsigned pick;
        int unsigned rlim;
        int unsigned clim;
        rlim     = (cfg_rows > ROWS_MAX) ? ROWS_MAX : cfg_rows;
        clim     = (cfg_cols > COLS_MAX) ? COLS_MAX : cfg_cols;
        pick     = $urandom_range(0, 99);
        w.kind   = mtcg_pkg::REQ_ACCUM;
        w.north  = COORD_W'({$urandom, $urandom});
        w.east   = COORD_W'({$urandom, $urandom});
        w.mask   = MASK_W'($urandom);
        w.rd_row = CELL_W'($urandom);
        w.rd_col = CELL_W'($urandom);
        if (pick < 15)
        begin
            w.kind = mtcg_pkg::REQ_READ;
            if (pick < 8 && rlim > 0 && clim > 0)
            begin
                w.rd_row = CELL_W'($urandom_range(0, rlim - 1));
                w.rd_col = CELL_W'($urandom_range(0, clim - 1));
            end
        end
        else if (pick >= 25)
        begin
            w.north = aim(cfg_on, cfg_inv_n, rlim, 1'b1);
            w.east  = aim(cfg_oe, cfg_inv_e, clim, 1'b0);
            w.mask  = (pick < 85) ? MASK_W'($urandom_range(1, 127))
                                  : MASK_W'(0 - $urandom_range(0, 128));
        end
        return w;
    endfunction

    function automatic probe_t probe(input logic kind,
                                     input logic signed [COORD_W-1:0] north,
                                     input logic signed [COORD_W-1:0] east,
                                     input logic signed [MASK_W-1:0] mask,
                                     input logic [CELL_W-1:0] rd_row,
                                     input logic [CELL_W-1:0] rd_col,
                                     input bit typed,
                                     input logic counted,
                                     input logic [CELL_W-1:0] row,
                                     input logic [CELL_W-1:0] col,
                                     input logic [CNT_W-1:0] count);
        probe_t p;
        p.w     = '{kind, north, east, mask, rd_row, rd_col};
        p.typed = typed;
        p.want  = '{counted, row, col, count};
        return p;
    endfunction

    // one request word; the expectation is queued at the accepting edge
    task automatic send_word(input bin_req_t w, input bit typed, input cell_res_t want);
        int        gap;
        cell_res_t pred;
        gap = idle_en ? $urandom_range(0, 17) : 0;
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {w.rd_col, w.rd_row, w.mask, w.east, w.north};
        s_axis_tuser  <= w.kind;
        do @(posedge clk); while (!s_axis_tready);
        pred = bin_request(w);
        pending_results.push_back(typed ? want : pred);
        n_words++;
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            mtcg_pkg::CFG_ORIGIN_NORTHING: cfg_on    = val[COORD_W-1:0];
            mtcg_pkg::CFG_ORIGIN_EASTING:  cfg_oe    = val[COORD_W-1:0];
            mtcg_pkg::CFG_INV_STEP_NORTH:  cfg_inv_n = val[INV_W-1:0];
            mtcg_pkg::CFG_INV_STEP_EAST:   cfg_inv_e = val[INV_W-1:0];
            mtcg_pkg::CFG_GRID_ROWS:       cfg_rows  = val[GRID_W-1:0];
            mtcg_pkg::CFG_GRID_COLS:       cfg_cols  = val[GRID_W-1:0];
            default: ;
        endcase
    endtask

    // full register set, written back to back
    task automatic program_grid(input logic [COORD_W-1:0] on, input logic [COORD_W-1:0] oe,
                                input logic [INV_W-1:0] inv_n, input logic [INV_W-1:0] inv_e,
                                input logic [GRID_W-1:0] rows,
                                input logic [GRID_W-1:0] cols);
        write_reg(mtcg_pkg::CFG_ORIGIN_NORTHING, CFG_W'(on));
        write_reg(mtcg_pkg::CFG_ORIGIN_EASTING, CFG_W'(oe));
        write_reg(mtcg_pkg::CFG_INV_STEP_NORTH, CFG_W'(inv_n));
        write_reg(mtcg_pkg::CFG_INV_STEP_EAST, CFG_W'(inv_e));
        write_reg(mtcg_pkg::CFG_GRID_ROWS, CFG_W'(rows));
        write_reg(mtcg_pkg::CFG_GRID_COLS, CFG_W'(cols));
        cfg_valid <= 1'b0;
        n_configs++;
    endtask

    // stop sending and wait for every outstanding result
    task automatic finish_phase();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic random_phase(input int count);
        cell_res_t none;
        none = '{1'b0, '0, '0, '0};
        repeat (count)
            send_word(random_word(), 1'b0, none);
        finish_phase();
    endtask

    // result side: random stalls, compare against the oldest expectation
    initial
    begin
        int        stall;
        cell_res_t got;
        cell_res_t exp_res;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = idle_en ? $urandom_range(0, 17) : 0;
            if (stall != 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
            got.counted = m_axis_tdata[0];
            got.row     = m_axis_tdata[8:1];
            got.col     = m_axis_tdata[16:9];
            got.count   = m_axis_tdata[17 +: CNT_W];
            if (pending_results.size() == 0)
            begin
                $error("result word with no request pending: %h", m_axis_tdata);
                err_cnt++;
            end
            else
            begin
                exp_res = pending_results.pop_front();
                n_checked++;
                if (got.counted && got.count == CNT_MAX)
                    n_sat++;
                if (got.counted)
                    n_hits++;
                if (got.counted !== exp_res.counted)
                begin
                    $error("counted: expected %0d, got %0d", exp_res.counted, got.counted);
                    err_cnt++;
                end
                if (got.row !== exp_res.row)
                begin
                    $error("cell_row: expected %0d, got %0d", exp_res.row, got.row);
                    err_cnt++;
                end
                if (got.col !== exp_res.col)
                begin
                    $error("cell_col: expected %0d, got %0d", exp_res.col, got.col);
                    err_cnt++;
                end
                if (got.count !== exp_res.count)
                begin
                    $error("cell_count: expected %0d, got %0d", exp_res.count, got.count);
                    err_cnt++;
                end
            end
        end
    end

    // watchdog on cycles with no word moving on any channel
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= WATCHDOG_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        probe_t    probes [$];
        bin_req_t  hit_word;
        cell_res_t none;
        logic signed [COORD_W-1:0] one;
        logic signed [COORD_W-1:0] c_max;
        logic signed [COORD_W-1:0] c_min;

        none  = '{1'b0, '0, '0, '0};
        one   = COORD_W'(65536);
        c_max = {1'b0, {(COORD_W-1){1'b1}}};
        c_min = {1'b1, {(COORD_W-1){1'b0}}};

        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= mtcg_pkg::REQ_ACCUM;
        m_axis_tready <= 1'b0;
        cfg_valid     <= 1'b0;
        cfg_index     <= mtcg_pkg::CFG_ORIGIN_NORTHING;
        cfg_data      <= '0;
        quiet         <= 0;
        idle_en   = 1'b1;
        err_cnt   = 0;
        n_words   = 0;
        n_checked = 0;
        n_hits    = 0;
        n_sat     = 0;
        n_configs = 0;

        // register and store state after reset
        cfg_on    = '0;
        cfg_oe    = '0;
        cfg_inv_n = mtcg_pkg::INV_STEP_RST;
        cfg_inv_e = mtcg_pkg::INV_STEP_RST;
        cfg_rows  = mtcg_pkg::GRID_SIZE_RST;
        cfg_cols  = mtcg_pkg::GRID_SIZE_RST;
        for (int i = 0; i < CELLS; i++)
            cell_cnt[i] = '0;

        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed words on the reset grid: unit steps, origin at zero
        probes.push_back(probe(mtcg_pkg::REQ_READ, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0));
        probes.push_back(probe(mtcg_pkg::REQ_READ, 0, 0, 0, 255, 255, 1, 0, 255, 255, 0));
        probes.push_back(probe(mtcg_pkg::REQ_ACCUM, 0, 0, 1, 255, 255, 1, 1, 0, 0, 1));
        probes.push_back(probe(mtcg_pkg::REQ_ACCUM, 0, 0, 127, 0, 0, 1, 1, 0, 0, 2));
        // mask at zero or below leaves the cell as it is
        probes.push_back(probe(mtcg_pkg::REQ_ACCUM, 0, 0, 0, 0, 0, 1, 0, 0, 0, 2));
        probes.push_back(probe(mtcg_pkg::REQ_ACCUM, 0, 0, -128, 0, 0, 1, 0, 0, 0, 2));
        probes.push_back(probe(mtcg_pkg::REQ_ACCUM, 0, 0, -1, 0, 0, 1, 0, 0, 0, 2));
        // far corner, then one past the far row edge, the near row edge and the far column edge
        probes.push_back(probe(mtcg_pkg::REQ_ACCUM, -255 * one, 255 * one, 5, 0, 0,
                               1, 1, 255, 255, 1));
        probes.push_back(probe(mtcg_pkg::REQ_ACCUM, -256 * one, 0, 1, 0, 0, 1, 0, 0, 0, 0));
        probes.push_back(probe(mtcg_pkg::REQ_ACCUM, one, 0, 1, 0, 0, 1, 0, 0, 0, 0));
        probes.push_back(probe(mtcg_pkg::REQ_ACCUM, 0, 256 * one, 1, 0, 0, 1, 0, 0, 0, 0));
        // rounding: exact halves go away from zero
        probes.push_back(probe(mtcg_pkg::REQ_ACCUM, -32768, 32768, 1, 0, 0, 1, 1, 1, 1, 1));
        probes.push_back(probe(mtcg_pkg::REQ_ACCUM, 32767, 98303, 1, 0, 0, 1, 1, 0, 1, 1));
        probes.push_back(probe(mtcg_pkg::REQ_ACCUM, 32768, 0, 1, 0, 0, 1, 0, 0, 0, 0));
        probes.push_back(probe(mtcg_pkg::REQ_ACCUM, -98304, -32768, 1, 0, 0, 1, 0, 0, 0, 0));
        probes.push_back(probe(mtcg_pkg::REQ_ACCUM, -32767, -32767, 1, 0, 0, 1, 1, 0, 0, 3));
        // coordinate extremes
        probes.push_back(probe(mtcg_pkg::REQ_ACCUM, c_max, c_min, 127, 0, 0, 1, 0, 0, 0, 0));
        probes.push_back(probe(mtcg_pkg::REQ_ACCUM, c_min, c_max, 1, 0, 0, 1, 0, 0, 0, 0));
        probes.push_back(probe(mtcg_pkg::REQ_ACCUM, -(100 * one + 16384), 37 * one + 49152, 9,
                               0, 0, 0, 0, 0, 0, 0));
        // read back what was counted; a read ignores the pixel fields
        probes.push_back(probe(mtcg_pkg::REQ_READ, 0, 0, 0, 1, 1, 1, 0, 1, 1, 1));
        probes.push_back(probe(mtcg_pkg::REQ_READ, 0, 0, 0, 0, 1, 1, 0, 0, 1, 1));
        probes.push_back(probe(mtcg_pkg::REQ_READ, 0, 0, 0, 255, 255, 1, 0, 255, 255, 1));
        probes.push_back(probe(mtcg_pkg::REQ_READ, 0, 0, 0, 0, 0, 1, 0, 0, 0, 3));
        probes.push_back(probe(mtcg_pkg::REQ_READ, -1, -1, -1, 15, 240, 1, 0, 15, 240, 0));
        probes.push_back(probe(mtcg_pkg::REQ_READ, 0, 0, 0, 100, 38, 0, 0, 0, 0, 0));
        foreach (probes[i])
            send_word(probes[i].w, probes[i].typed, probes[i].want);
        finish_phase();

        // extreme origins and finest steps; row count above the store
        program_grid(c_max, c_min, '1, '1, 9'd300, 9'd256);
        random_phase(PHASE_WORDS);

        // zero reciprocal on rows, coarsest step on columns
        program_grid('0, '0, '0, 32'd1, 9'd8, 9'd256);
        random_phase(PHASE_WORDS);

        // empty grid: no pixel can land
        program_grid(COORD_W'($signed($urandom)) <<< 8, COORD_W'($signed($urandom)) <<< 8,
                     mtcg_pkg::INV_STEP_RST, mtcg_pkg::INV_STEP_RST, 9'd0, 9'd1);
        random_phase(PHASE_WORDS);

        // small grids with arbitrary steps so cells fill up
        program_grid(COORD_W'($signed($urandom)) <<< 8, COORD_W'($signed($urandom)) <<< 8,
                     $urandom_range(1 << 10, 1 << 22), $urandom_range(1 << 10, 1 << 22),
                     GRID_W'($urandom_range(1, 16)), GRID_W'($urandom_range(1, 16)));
        random_phase(PHASE_WORDS);

        // single row, column count above the store
        program_grid('0, '0, mtcg_pkg::INV_STEP_RST, mtcg_pkg::INV_STEP_RST, 9'd1, 9'd511);
        random_phase(PHASE_WORDS);

        // back-to-back hits on one cell, no idling, then read it back
        program_grid('0, '0, mtcg_pkg::INV_STEP_RST, mtcg_pkg::INV_STEP_RST,
                     mtcg_pkg::GRID_SIZE_RST, mtcg_pkg::GRID_SIZE_RST);
        idle_en  = 1'b0;
        hit_word = '{mtcg_pkg::REQ_ACCUM, -3 * one, 4 * one, 1, 0, 0};
        repeat (HIT_WORDS)
            send_word(hit_word, 1'b0, none);
        hit_word = '{mtcg_pkg::REQ_READ, 0, 0, 0, 3, 4};
        send_word(hit_word, 1'b0, none);
        finish_phase();
        idle_en = 1'b1;

        // full-size random grid
        program_grid(COORD_W'($signed($urandom)) <<< 8, COORD_W'($signed($urandom)) <<< 8,
                     $urandom_range(1 << 14, 1 << 18), $urandom_range(1 << 14, 1 << 18),
                     GRID_W'($urandom_range(1, 256)), GRID_W'($urandom_range(1, 256)));
        random_phase(PHASE_WORDS);

        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d request words over %0d grid settings, %0d results checked.",
                 n_words, n_configs, n_checked);
        $display("Cell increments seen: %0d, of them at the count ceiling: %0d.", n_hits, n_sat);
        if (err_cnt == 0 && pending_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
